// ===== rtl/core/ied_pkg.sv =====
`timescale 1ns / 1ps
// ied_pkg: beat types and fixed constants of the index entry descrambler.
// No dependencies; imported by every module under rtl/core.

package ied_pkg;

    localparam int ENTRY_BYTES = 20;
    localparam int POS_W       = $clog2(ENTRY_BYTES);
    localparam int COUNT_W     = 17;
    localparam int OFFSET_BASE = 16;
    localparam int SIZE_BASE   = 12;
    localparam int NAME_BASE   = 0;
    localparam int TAIL_BASE   = 8;

    localparam logic [7:0] KEY_MUL = 8'd3;
    localparam logic [7:0] KEY_INC = 8'd1;

    localparam logic [POS_W-1:0] SLOT_OF_POS [ENTRY_BYTES] = '{
        5'd17, 5'd2,  5'd8,  5'd19, 5'd0,  5'd5,  5'd10, 5'd13, 5'd1,  5'd15,
        5'd6,  5'd4,  5'd11, 5'd16, 5'd3,  5'd9,  5'd18, 5'd12, 5'd7,  5'd14
    };

    typedef struct packed {
        logic [7:0] index_byte;
        logic       start_of_index;
    } in_beat_t;

    typedef struct packed {
        logic [31:0]        entry_offset;
        logic [31:0]        stored_size;
        logic [63:0]        name_head;
        logic [31:0]        name_tail;
        logic [COUNT_W-1:0] entry_number;
    } out_beat_t;

    typedef struct packed {
        logic advance;
        logic emit;
    } ied_ctl_t;

endpackage

// ===== rtl/core/ied_decoder.sv =====
`timescale 1ns / 1ps
// ied_decoder: running key, byte position, entry buffer and entry count.
// Depends on ied_pkg.

module ied_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat_valid,
    input  ied_pkg::in_beat_t beat,
    input  logic              out_free,
    input  logic [7:0]        initial_key,
    output ied_pkg::ied_ctl_t ctl,
    output ied_pkg::out_beat_t result
);
    import ied_pkg::*;

    logic [7:0]         key_reg;
    logic [7:0]         key_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         entry_buf_reg [ENTRY_BYTES];

    logic [7:0]         key_cur;
    logic [POS_W-1:0]   pos_cur;
    logic [COUNT_W-1:0] count_cur;
    logic [POS_W-1:0]   slot;
    logic [7:0]         decoded;
    logic               last;
    logic [7:0]         view [ENTRY_BYTES];

    always_comb
    begin
        key_cur   = beat.start_of_index ? initial_key : key_reg;
        count_cur = beat.start_of_index ? '0 : count_reg;
        if (beat.start_of_index || (pos_reg >= POS_W'(ENTRY_BYTES)))
        begin
            pos_cur = '0;
        end
        else
        begin
            pos_cur = pos_reg;
        end
        last        = (pos_cur == POS_W'(ENTRY_BYTES - 1));
        slot        = SLOT_OF_POS[pos_cur];
        decoded     = beat.index_byte ^ key_cur;
        ctl.advance = beat_valid && (!last || out_free);
        ctl.emit    = ctl.advance && last;
        key_next    = 8'(key_cur * KEY_MUL + KEY_INC);
        pos_next    = last ? '0 : POS_W'(pos_cur + 1'b1);
        count_next  = last ? COUNT_W'(count_cur + 1'b1) : count_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else if (ctl.advance)
        begin
            key_reg   <= key_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            entry_buf_reg[slot] <= decoded;
        end
    end

    // merge the byte being written so the last byte shows up in this beat
    always_comb
    begin
        for (int i = 0; i < ENTRY_BYTES; i++)
        begin
            view[i] = (slot == POS_W'(i)) ? decoded : entry_buf_reg[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            result.entry_offset[8*i +: 8] = view[OFFSET_BASE + i];
            result.stored_size[8*i +: 8]  = view[SIZE_BASE + i];
            result.name_tail[8*i +: 8]    = view[TAIL_BASE + i];
        end
        for (int i = 0; i < 8; i++)
        begin
            result.name_head[8*i +: 8] = view[NAME_BASE + i];
        end
        result.entry_number = count_cur;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(ENTRY_BYTES))
        else $error("byte position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> (pos_reg == '0))
        else $error("position not cleared after entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> (count_reg == $past(COUNT_W'(count_cur + 1'b1))))
        else $error("entry count did not step");

endmodule

// ===== rtl/core/ied_out_stage.sv =====
`timescale 1ns / 1ps
// ied_out_stage: result register holding one entry beat for the receiver.
// Depends on ied_pkg.

module ied_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ied_pkg::out_beat_t load_beat,
    input  logic               out_stall,
    output logic               out_free,
    output logic               out_valid,
    output ied_pkg::out_beat_t out_beat
);
    import ied_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_beat_t beat_reg;

    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= load_beat;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("result overwritten before it was taken");

endmodule

// ===== rtl/core/index_entry_descrambler_top.sv =====
`timescale 1ns / 1ps
// index_entry_descrambler_top: input register, decoder and result register.
// Depends on ied_pkg, ied_decoder and ied_out_stage.
//
// Usage:
//   in channel  : one scrambled index byte per beat, with start_of_index set
//                 on the first byte of the index (reloads the key from
//                 initial_key, clears byte position and entry count).
//   out channel : one beat per 20 input bytes carrying offset, size, the raw
//                 12 name bytes and the entry number.
//   cfg channel : writes initial_key; always ready. Write only while idle.
//   Throughput is one input byte per cycle unless stalled, set by the single
//   input register feeding the decoder. An entry's result beat is registered
//   in the result register, driving out_valid, when its last byte is decoded.
//   When the receiver stalls, the held result stays; bytes keep flowing until
//   the next entry's last byte reaches the decoder, then in_stall rises.
//   Reset clears key, position, count, initial_key and all valid flags; the
//   entry buffer holds garbage until written.

module index_entry_descrambler_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ied_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_stall,
    output ied_pkg::out_beat_t out_beat,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import ied_pkg::*;

    logic      a_valid_reg;
    logic      a_valid_next;
    in_beat_t  a_beat_reg;
    logic      accept;
    logic      out_free;
    ied_ctl_t  ctl;
    out_beat_t result;
    logic [7:0] initial_key_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = a_valid_reg && !ctl.advance;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (ctl.advance)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            initial_key_reg <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                initial_key_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_beat_reg <= in_beat;
        end
    end

    ied_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_valid  (a_valid_reg),
        .beat        (a_beat_reg),
        .out_free    (out_free),
        .initial_key (initial_key_reg),
        .ctl         (ctl),
        .result      (result)
    );

    ied_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ctl.emit),
        .load_beat (result),
        .out_stall (out_stall),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_beat  (out_beat)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg)
        else $error("input stalled with empty input register");

endmodule
